/* design/imu_report_stream_parser_defines.svh */
// ----------------------------------------------------------------------------
// imu_report_stream_parser_defines
// assertion macros used by imursp_checker
// ----------------------------------------------------------------------------
`ifndef IMU_REPORT_STREAM_PARSER_DEFINES_SVH
`define IMU_REPORT_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define IMURSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imursp assertion failed");

// next-cycle implication, disabled while reset is low
`define IMURSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imursp assertion failed");

`endif

/* design/imursp_pkg.sv */
// ----------------------------------------------------------------------------
// imursp_pkg
// constants and types of the sensor report stream parser
// ----------------------------------------------------------------------------
package imursp_pkg;

    localparam int DEF_MAX_PACKET_BYTES = 128;

    // packet layout
    localparam int CHANNEL_BYTE      = 2;
    localparam int TAG_BYTE          = 4;
    localparam int FIRST_REPORT_BYTE = 9;

    localparam logic [7:0] CHANNEL_REPORTS    = 8'h03;
    localparam logic [7:0] TAG_BASE_TIMESTAMP = 8'hFB;
    localparam logic [7:0] ID_ACCEL           = 8'h01;
    localparam logic [7:0] ID_GYRO            = 8'h02;

    // byte positions inside one report
    localparam int REPORT_LEN = 10;
    localparam int RP_W       = 4;
    localparam logic [RP_W-1:0] RP_ID         = 4'd0;
    localparam logic [RP_W-1:0] RP_STATUS     = 4'd2;
    localparam logic [RP_W-1:0] RP_AXIS_FIRST = 4'd4;
    localparam logic [RP_W-1:0] RP_AXIS_LAST  = 4'd8;
    localparam logic [RP_W-1:0] RP_LAST       = 4'(REPORT_LEN - 1);
    localparam int AXIS_BYTES = 5;

    localparam int VALUE_W  = 17;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 56;

    typedef struct packed {
        logic                      sensor;
        logic signed [VALUE_W-1:0] x_value;
        logic signed [VALUE_W-1:0] y_value;
        logic signed [VALUE_W-1:0] z_value;
        logic [1:0]                accuracy;
    } t_result;

endpackage

/* design/imu_report_stream_parser.sv */
// ----------------------------------------------------------------------------
// imu_report_stream_parser
// parses accelerometer and gyroscope reports out of sensor-hub packet bytes
// ----------------------------------------------------------------------------
// path: the beat carrying a report's last byte enters the input register, and the
//   parse step then moves the report into the result register
// throughput: one byte beat per cycle while no report waits on the receiver
// reset: synchronous active-low, clears the valid flags of both registers and the
//   packet parse state; no clearing pass, the block takes beats right after reset
module imu_report_stream_parser
    import imursp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte input
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [7:0] data_byte
    input  logic                i_s_tlast,   // last_byte
    // report output
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // [16:0] x_value, [33:17] y_value,
                                             // [50:34] z_value, [52:51] accuracy,
                                             // [55:53] zero
    output logic                o_m_tuser    // sensor
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    emit;
    t_result result;

    // the parse step runs when a byte waits and the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata[7:0];
            r_in_last <= i_s_tlast;
        end
    end

    imursp_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_emit   (emit),
        .o_result (result)
    );

    // a byte without a report still moves through, leaving the result empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.sensor;
    assign o_m_tdata  = {3'b000, r_out.accuracy, r_out.z_value, r_out.y_value,
                         r_out.x_value};

endmodule

/* design/imursp_core.sv */
// ----------------------------------------------------------------------------
// imursp_core
// per-packet parse state and report decode, one byte per step
// ----------------------------------------------------------------------------
module imursp_core
    import imursp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_emit,
    output t_result       o_result
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    logic             r_accepted, n_accepted;
    logic [RP_W-1:0]  r_rp, n_rp;
    logic             r_gyro, n_gyro;
    logic [1:0]       r_acc, n_acc;
    logic [7:0]       r_axis [AXIS_BYTES];

    logic                      wr_axis;
    logic signed [15:0]        raw_x, raw_y, raw_z;
    logic signed [VALUE_W-1:0] ext_x, ext_y, ext_z;

    assign raw_x = {r_axis[1], r_axis[0]};
    assign raw_y = {r_axis[3], r_axis[2]};
    assign raw_z = {i_byte, r_axis[4]};
    assign ext_x = VALUE_W'(raw_x);
    assign ext_y = VALUE_W'(raw_y);
    assign ext_z = VALUE_W'(raw_z);

    always_comb begin
        logic acc_chk;
        n_byte_pos = r_byte_pos;
        n_accepted = r_accepted;
        n_rp       = r_rp;
        n_gyro     = r_gyro;
        n_acc      = r_acc;
        wr_axis    = 1'b0;
        o_emit     = 1'b0;
        acc_chk    = r_accepted;
        if (i_step && (r_byte_pos < POS_W'(MAX_PACKET_BYTES))) begin
            if (r_byte_pos == POS_W'(CHANNEL_BYTE) && i_byte != CHANNEL_REPORTS)
                acc_chk = 1'b0;
            if (r_byte_pos == POS_W'(TAG_BYTE) && i_byte != TAG_BASE_TIMESTAMP)
                acc_chk = 1'b0;
            if (r_byte_pos >= POS_W'(FIRST_REPORT_BYTE) && acc_chk) begin
                if (r_rp == RP_ID) begin
                    if (i_byte == ID_ACCEL)
                        n_gyro = 1'b0;
                    else if (i_byte == ID_GYRO)
                        n_gyro = 1'b1;
                    else
                        acc_chk = 1'b0;
                end else if (r_rp == RP_STATUS) begin
                    n_acc = i_byte[1:0];
                end else if (r_rp >= RP_AXIS_FIRST && r_rp <= RP_AXIS_LAST) begin
                    wr_axis = 1'b1;
                end else if (r_rp == RP_LAST) begin
                    o_emit = 1'b1;
                end
                if (acc_chk)
                    n_rp = (r_rp >= RP_LAST) ? '0 : r_rp + RP_W'(1);
            end
            n_accepted = acc_chk;
            n_byte_pos = r_byte_pos + POS_W'(1);
        end
        // end of packet: back to the idle packet state
        if (i_step && i_last) begin
            n_byte_pos = '0;
            n_accepted = 1'b1;
            n_rp       = '0;
            n_gyro     = 1'b0;
            n_acc      = '0;
        end
    end

    always_comb begin
        o_result.sensor   = r_gyro;
        o_result.x_value  = r_gyro ? ext_y : -ext_y;
        o_result.y_value  = r_gyro ? ext_x : -ext_x;
        o_result.z_value  = -ext_z;
        o_result.accuracy = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_accepted <= 1'b1;
            r_rp       <= '0;
            r_gyro     <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_byte_pos <= n_byte_pos;
            r_accepted <= n_accepted;
            r_rp       <= n_rp;
            r_gyro     <= n_gyro;
            r_acc      <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < AXIS_BYTES; i++) begin
            if (wr_axis && r_rp == RP_AXIS_FIRST + RP_W'(i))
                r_axis[i] <= i_byte;
        end
    end

endmodule

/* design/imursp_checker.sv */
// ----------------------------------------------------------------------------
// imursp_checker
// port-level checks of the report stream parser
// ----------------------------------------------------------------------------
`include "imu_report_stream_parser_defines.svh"

module imursp_checker
    import imursp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_s_tlast,
    input  logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] o_m_tdata,
    input  logic                o_m_tuser
);

    logic s_beat;
    assign s_beat = i_s_tvalid && o_s_tready;

    // report beat as a whole, and a report waiting on the receiver
    logic [M_DATA_W:0] out_beat;
    logic              out_stall;
    assign out_beat  = {o_m_tuser, o_m_tdata};
    assign out_stall = o_m_tvalid && !i_m_tready;

    // a stalled report holds
    `IMURSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(out_beat))

    // a new report needs an accepted byte beat before it
    `IMURSP_ASSERT_IMPLY(a_out_cause, i_clk, i_rst_n, $rose(o_m_tvalid), $past(s_beat, 2))

    // z is always negated and widened, so it never reads minus full scale
    `IMURSP_ASSERT_IMPLY(a_z_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[50:34] != 17'h18000)

    // pad bits of the result beat stay zero
    `IMURSP_ASSERT_IMPLY(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[55:53] == 3'b000)

endmodule

bind imu_report_stream_parser imursp_checker u_imursp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
